/* hw/rtl/pool_slot_allocator_top_assert.svh */
// Assertion macros shared by the pool slot allocator RTL.
// Included by every module that carries concurrent assertions.
`ifndef POOL_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define POOL_SLOT_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pool slot allocator: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PSA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pool slot allocator: next-cycle check failed");

`endif

/* hw/rtl/psa_pkg.sv */
// Package for the pool slot allocator: sizes, opcodes, state type and the
// structs that travel between the top level and the slot cells. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package psa_pkg;

    localparam int POOL_SIZE  = 1024;
    localparam int OWNER_BITS = 8;

    // Widths fixed by the item fields.
    localparam int SLOT_W = 10;
    localparam int HW_W   = 11;

    // Each cell holds CELL_SLOTS active bits; the index splits into cell and local part.
    localparam int CELL_SLOTS = 32;
    localparam int LOC_W      = $clog2(CELL_SLOTS);
    localparam int CID_W      = SLOT_W - LOC_W;
    localparam int NUM_CELLS  = (POOL_SIZE + CELL_SLOTS - 1) / CELL_SLOTS;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FREE,
        ST_SCAN,
        ST_HOLD
    } t_state;

    // Search token that walks down the row of cells, one cell per cycle.
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [SLOT_W-1:0] first_idx;
        logic              hint_valid;
        logic [SLOT_W-1:0] hint_idx;
        logic              hint_ok;
    } t_tok;

    // Write command broadcast to every cell; only the addressed cell acts.
    typedef struct packed {
        logic                  set;
        logic                  clr;
        logic [SLOT_W-1:0]     idx;
        logic [OWNER_BITS-1:0] owner;
    } t_wr;

    typedef struct packed {
        logic              granted;
        logic [SLOT_W-1:0] idx;
        logic [HW_W-1:0]   hw;
    } t_res;

endpackage

`default_nettype wire

/* hw/rtl/psa_cell.sv */
// One cell of the slot row: holds a slice of active bits and owner ids,
// and advances the search token by one cell per cycle. Depends on psa_pkg.
`timescale 1ns / 1ps
`default_nettype none

`include "pool_slot_allocator_top_assert.svh"

module psa_cell (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic [psa_pkg::CID_W-1:0] i_cell_id,
    input  wire psa_pkg::t_tok            i_tok,
    output psa_pkg::t_tok                 o_tok,
    input  wire psa_pkg::t_wr             i_wr
);
    import psa_pkg::*;

    logic [CELL_SLOTS-1:0] r_active;
    logic [OWNER_BITS-1:0] r_owner_mem [CELL_SLOTS];
    t_tok                  r_tok;
    t_tok                  n_tok;

    logic [CELL_SLOTS-1:0] free_vec;
    logic                  any_free;
    logic [LOC_W-1:0]      first_loc;
    logic                  hint_hit;
    logic                  wr_hit;
    logic [LOC_W-1:0]      wr_loc;

    // A slot is free when it exists in the pool and is not active.
    always_comb begin
        for (int j = 0; j < CELL_SLOTS; j++) begin
            free_vec[j] = !r_active[j] &&
                ((32'(i_cell_id) * 32'(CELL_SLOTS) + 32'(j)) < 32'(POOL_SIZE));
        end
    end

    // Lowest free slot inside this cell.
    always_comb begin
        any_free  = 1'b0;
        first_loc = '0;
        for (int j = CELL_SLOTS - 1; j >= 0; j--) begin
            if (free_vec[j]) begin
                any_free  = 1'b1;
                first_loc = LOC_W'(j);
            end
        end
    end

    assign hint_hit = i_tok.hint_valid &&
                      (i_tok.hint_idx[SLOT_W-1:LOC_W] == i_cell_id) &&
                      free_vec[i_tok.hint_idx[LOC_W-1:0]];

    always_comb begin
        n_tok           = i_tok;
        n_tok.found     = i_tok.found || any_free;
        n_tok.first_idx = i_tok.found ? i_tok.first_idx : {i_cell_id, first_loc};
        n_tok.hint_ok   = i_tok.hint_ok || hint_hit;
    end

    assign wr_hit = (i_wr.idx[SLOT_W-1:LOC_W] == i_cell_id);
    assign wr_loc = i_wr.idx[LOC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok    <= '0;
            r_active <= '0;
        end else begin
            r_tok <= n_tok;
            if (wr_hit && i_wr.set) begin
                r_active[wr_loc] <= 1'b1;
            end else if (wr_hit && i_wr.clr) begin
                r_active[wr_loc] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_hit && i_wr.set) begin
            r_owner_mem[wr_loc] <= i_wr.owner;
        end
    end

    assign o_tok = r_tok;

    // Slot writes only happen at commit, never while a token is entering this cell.
    `PSA_ASSERT_IMP(a_no_write_during_scan, i_clk, i_rst_n, i_tok.valid, !(i_wr.set || i_wr.clr))

endmodule

`default_nettype wire

/* hw/rtl/pool_slot_allocator_top.sv */
// Top level of the pool slot allocator: request channel, row of slot cells,
// commit logic and result register. Depends on psa_pkg and psa_cell.
//
// Usage:
// The request channel carries one item per request: i_op (0 allocate, 1 free),
// i_slot_to_free and i_owner_id. An item is taken at a rising edge where
// i_in_valid is high and o_in_stall is low. Every item yields exactly one
// result item on o_granted, o_slot_index and o_high_water, offered with
// o_out_valid and taken when i_out_stall is low.
// The block works on one item at a time. A free commits in the cycle after it
// is taken. An allocate sends a search token down the row of NUM_CELLS cells
// (32 with the default pool of 1024 slots in cells of 32), one cell per cycle,
// and commits when the token leaves the last cell; that token walk sets the
// allocate rate.
// The result register decouples the two sides: a new item may be taken while
// an older result is still stalled. If a finished result finds the register
// still occupied, it waits in a holding register and o_in_stall stays high.
// Reset is synchronous and active low: all slots become inactive, the
// remembered slot is dropped, the bound returns to zero and no result is shown.
`timescale 1ns / 1ps
`default_nettype none

`include "pool_slot_allocator_top_assert.svh"

module pool_slot_allocator_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_op,
    input  wire logic [psa_pkg::SLOT_W-1:0]     i_slot_to_free,
    input  wire logic [psa_pkg::OWNER_BITS-1:0] i_owner_id,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_granted,
    output logic [psa_pkg::SLOT_W-1:0]          o_slot_index,
    output logic [psa_pkg::HW_W-1:0]            o_high_water
);
    import psa_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [SLOT_W-1:0]     r_idx;
    logic [OWNER_BITS-1:0] r_owner;
    logic                  r_hint_valid;
    logic [SLOT_W-1:0]     r_hint_index;
    logic [HW_W-1:0]       r_bound;
    logic [HW_W-1:0]       n_bound;
    t_res                  r_res;
    t_res                  res;

    logic                  r_out_valid;
    logic                  r_out_granted;
    logic [SLOT_W-1:0]     r_out_idx;
    logic [HW_W-1:0]       r_out_hw;

    logic                  acc_in;
    logic                  out_free;
    logic                  commit;
    logic                  load_out;
    logic                  in_pool;
    logic [HW_W-1:0]       grant_top;
    logic [HW_W-1:0]       out_idx_ext;
    t_wr                   wr;
    t_tok                  tok [NUM_CELLS+1];
    t_tok                  tok_last;

    assign acc_in   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign tok_last = tok[NUM_CELLS];
    assign in_pool  = (32'(r_idx) < 32'(POOL_SIZE));

    // A new search enters the first cell at the edge where an allocate is taken.
    always_comb begin
        tok[0]            = '0;
        tok[0].valid      = acc_in && (i_op == OP_ALLOC);
        tok[0].hint_valid = r_hint_valid;
        tok[0].hint_idx   = r_hint_index;
    end

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        psa_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cell_id (CID_W'(k)),
            .i_tok     (tok[k]),
            .o_tok     (tok[k+1]),
            .i_wr      (wr)
        );
    end

    // Result and new bound at commit. The remembered slot wins over first fit
    // when it is still inactive.
    always_comb begin
        res       = '0;
        n_bound   = r_bound;
        grant_top = '0;
        if (r_state == ST_FREE) begin
            res.idx = r_idx;
            if (in_pool && (r_bound != '0) && ({1'b0, r_idx} == r_bound - 1'b1)) begin
                n_bound = r_bound - 1'b1;
            end
        end else begin
            res.granted = tok_last.hint_ok || tok_last.found;
            if (tok_last.hint_ok) begin
                res.idx = tok_last.hint_idx;
            end else if (tok_last.found) begin
                res.idx = tok_last.first_idx;
            end
            grant_top = {1'b0, res.idx} + 1'b1;
            if (res.granted && (r_bound < grant_top)) begin
                n_bound = grant_top;
            end
        end
        res.hw = n_bound;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc_in) begin
                    n_state = (i_op == OP_FREE) ? ST_FREE : ST_SCAN;
                end
            end
            ST_FREE: begin
                n_state = out_free ? ST_IDLE : ST_HOLD;
            end
            ST_SCAN: begin
                if (tok_last.valid) begin
                    n_state = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State-driven outputs.
    always_comb begin
        o_in_stall = 1'b1;
        commit     = 1'b0;
        load_out   = 1'b0;
        wr         = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            ST_FREE: begin
                commit   = 1'b1;
                load_out = out_free;
                wr.clr   = in_pool;
                wr.idx   = r_idx;
            end
            ST_SCAN: begin
                commit   = tok_last.valid;
                load_out = tok_last.valid && out_free;
                wr.set   = tok_last.valid && res.granted;
                wr.idx   = res.idx;
                wr.owner = r_owner;
            end
            ST_HOLD: begin
                load_out = out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_hint_valid <= 1'b0;
            r_hint_index <= '0;
            r_bound      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_bound <= n_bound;
                if (r_state == ST_FREE && in_pool) begin
                    r_hint_valid <= 1'b1;
                    r_hint_index <= r_idx;
                end else if (r_state == ST_SCAN && res.granted) begin
                    r_hint_valid <= 1'b0;
                end
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_idx   <= i_slot_to_free;
            r_owner <= i_owner_id;
        end
        if (commit) begin
            r_res <= res;
        end
        if (load_out) begin
            if (r_state == ST_HOLD) begin
                r_out_granted <= r_res.granted;
                r_out_idx     <= r_res.idx;
                r_out_hw      <= r_res.hw;
            end else begin
                r_out_granted <= res.granted;
                r_out_idx     <= res.idx;
                r_out_hw      <= res.hw;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_granted    = r_out_granted;
    assign o_slot_index = r_out_idx;
    assign o_high_water = r_out_hw;

    assign out_idx_ext  = {1'b0, r_out_idx};

    // A search token only leaves the row while the block is scanning.
    `PSA_ASSERT_IMP(a_token_in_scan, i_clk, i_rst_n, tok_last.valid, r_state == ST_SCAN)
    // A result waits in the holding register only behind an occupied output.
    `PSA_ASSERT_IMP(a_hold_needs_out, i_clk, i_rst_n, r_state == ST_HOLD, r_out_valid)
    // A granted slot always lies below the reported bound.
    `PSA_ASSERT_IMP(a_grant_below_bound, i_clk, i_rst_n, o_out_valid && o_granted, out_idx_ext < o_high_water)
    // Granting a slot leaves a nonzero bound behind.
    `PSA_ASSERT_NXT(a_grant_raises_bound, i_clk, i_rst_n, commit && res.granted, r_bound != '0)

endmodule

`default_nettype wire

/* verif/tb_pool_slot_allocator_top.sv */
// Self-checking testbench for pool_slot_allocator_top: directed corner cases, back-pressure
// and random allocate/free traffic, checked against a cycle-free predictor of the slot pool.
// Depends on psa_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module tb_pool_slot_allocator_top;

    import psa_pkg::*;

    // Clock, reset and every block input start at a known value.
    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  i_op           = OP_ALLOC;
    logic [SLOT_W-1:0]     i_slot_to_free = '0;
    logic [OWNER_BITS-1:0] i_owner_id     = '0;
    logic                  i_out_stall    = 1'b0;

    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  o_granted;
    logic [SLOT_W-1:0]     o_slot_index;
    logic [HW_W-1:0]       o_high_water;

    pool_slot_allocator_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_slot_to_free (i_slot_to_free),
        .i_owner_id     (i_owner_id),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_granted      (o_granted),
        .o_slot_index   (o_slot_index),
        .o_high_water   (o_high_water)
    );

    always #1 i_clk = ~i_clk;

    // Predicted pool state. The owner ids are never read back by the block, so
    // the predictor keeps only what can be observed: the active bits, the
    // remembered freed slot and the high-water bound.
    logic [POOL_SIZE-1:0] slot_busy = '0;
    int                   busy_count = 0;
    logic                 hint_held = 1'b0;
    logic [SLOT_W-1:0]    hint_slot = '0;
    logic [HW_W-1:0]      bound = '0;

    // Results still owed by the block, oldest first.
    t_res pending_results[$];
    int   mismatch_count = 0;

    // Idling rates in percent, changed by the tests. A hold-off request asks
    // the receiver to stall for that many cycles in a row.
    int send_idle_pct  = 20;
    int recv_stall_pct = 20;
    int holdoff_req    = 0;

    // Applies one request to the predicted pool and returns the result the
    // block must produce for it.
    function automatic t_res predict_request(input logic op, input logic [SLOT_W-1:0] fidx);
        t_res r;
        int   i;
        r = '0;
        if (op == OP_ALLOC) begin
            // The remembered slot wins if it is still inactive; otherwise the
            // lowest inactive slot is taken.
            if (hint_held && !slot_busy[hint_slot]) begin
                r.granted = 1'b1;
                r.idx     = hint_slot;
            end else begin
                for (i = 0; i < POOL_SIZE; i++) begin
                    if (!slot_busy[i]) begin
                        r.granted = 1'b1;
                        r.idx     = SLOT_W'(i);
                        break;
                    end
                end
            end
            // A failed allocation changes nothing, the hint included.
            if (r.granted) begin
                slot_busy[r.idx] = 1'b1;
                busy_count++;
                hint_held = 1'b0;
                if (bound < r.idx + 1)
                    bound = HW_W'(r.idx) + 1'b1;
            end
        end else begin
            r.idx = fidx;
            if (fidx < POOL_SIZE) begin
                hint_held = 1'b1;
                hint_slot = fidx;
                // Only a free of the slot just below the bound pulls the bound down,
                // and only by one; the bound never drops below zero.
                if (bound != 0 && fidx == bound - 1)
                    bound = bound - 1'b1;
                if (slot_busy[fidx])
                    busy_count--;
                slot_busy[fidx] = 1'b0;
            end
        end
        r.hw = bound;
        return r;
    endfunction

    // Offers one item, holding it until it is taken, and records what the
    // block owes for it. Called right after a rising edge. Valid stays high on
    // return so that the next item can follow back to back.
    task automatic send_item(input logic op, input logic [SLOT_W-1:0] fidx,
                             input logic [OWNER_BITS-1:0] owner);
        int gap;
        if ($urandom_range(99) < send_idle_pct) begin
            // Mostly short gaps, now and then one long enough to span a scan.
            gap = $urandom_range(1, ($urandom_range(3) == 0) ? 40 : 4);
            i_in_valid     <= 1'b0;
            i_op           <= 1'($urandom_range(1));
            i_slot_to_free <= SLOT_W'($urandom);
            i_owner_id     <= OWNER_BITS'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_op           <= op;
        i_slot_to_free <= fidx;
        i_owner_id     <= owner;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(predict_request(op, fidx));
    endtask

    // Stops offering items and waits until every owed result has come back.
    // At least one edge passes, so valid is never lowered and raised in one step.
    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // One random request. Frees of busy slots keep the traffic meaningful;
    // the rest free arbitrary slots, most of them already inactive.
    task automatic send_random_request(input int alloc_pct, input int busy_free_pct);
        int                r;
        int                n;
        logic [SLOT_W-1:0] pick;
        r    = $urandom_range(99);
        pick = SLOT_W'($urandom);
        if (r < alloc_pct) begin
            send_item(OP_ALLOC, SLOT_W'($urandom), OWNER_BITS'($urandom));
        end else begin
            if (r < alloc_pct + busy_free_pct && busy_count > 0) begin
                for (n = 0; n < POOL_SIZE && !slot_busy[pick]; n++)
                    pick = pick + 1'b1;
            end
            send_item(OP_FREE, pick, OWNER_BITS'($urandom));
        end
    endtask

    // Receiver: random stalls, or a long counted hold-off when one is asked.
    always @(posedge i_clk) begin : drive_out_stall
        int holdoff_left;
        if (holdoff_req > 0) begin
            holdoff_left = holdoff_req;
            holdoff_req  = 0;
        end
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (holdoff_left > 0) begin
            i_out_stall <= 1'b1;
            holdoff_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Every result taken is compared with the oldest owed one.
    always @(posedge i_clk) begin : check_results
        t_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with nothing owed: granted %0d slot %0d high_water %0d",
                             $realtime, o_granted, o_slot_index, o_high_water);
            end else begin
                want = pending_results.pop_front();
                if (o_granted !== want.granted || o_slot_index !== want.idx ||
                    o_high_water !== want.hw) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: expected granted %0d slot %0d high_water %0d, got %0d %0d %0d",
                                 $realtime, want.granted, want.idx, want.hw,
                                 o_granted, o_slot_index, o_high_water);
                end
            end
        end
    end

    // Corner cases on an empty pool: free with the bound at zero, free of an
    // inactive slot, the hint taking the top slot and the bound reaching its
    // maximum, a newer hint replacing an older one, a free at the top that
    // lowers the bound, and extreme field values.
    task automatic test_directed_corners();
        send_item(OP_FREE,  10'd0,     8'h00);
        send_item(OP_FREE,  10'd1023,  8'hFF);
        send_item(OP_ALLOC, 10'd0,     8'hFF);
        send_item(OP_ALLOC, 10'd1023,  8'h00);
        send_item(OP_ALLOC, 10'h155,   8'h55);
        send_item(OP_FREE,  10'd1023,  8'hAA);
        send_item(OP_FREE,  10'd1023,  8'h55);
        send_item(OP_ALLOC, 10'h2AA,   8'hAA);
        send_item(OP_FREE,  10'd1,     8'h00);
        send_item(OP_FREE,  10'd0,     8'hFF);
        send_item(OP_ALLOC, 10'd0,     8'h01);
        send_item(OP_ALLOC, 10'd0,     8'h80);
        send_item(OP_FREE,  10'd1022,  8'h00);
        send_item(OP_FREE,  10'd1023,  8'h00);
        send_item(OP_FREE,  10'd1022,  8'h00);
        send_item(OP_ALLOC, 10'h155,   8'h55);
        send_item(OP_ALLOC, 10'h2AA,   8'hAA);
        send_item(OP_FREE,  10'h155,   8'hFF);
        send_item(OP_FREE,  10'h2AA,   8'h00);
        send_item(OP_ALLOC, 10'd1023,  8'hFF);
        wait_all_results();
    endtask

    // A stretch with no idling on either side.
    task automatic test_back_to_back();
        int n;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (n = 0; n < 40; n++)
            send_random_request(50, 40);
        wait_all_results();
        send_idle_pct  = 20;
        recv_stall_pct = 20;
    endtask

    // The receiver holds off while requests, mostly frees, keep coming, so the result and
    // holding registers fill and the block stalls its input.
    task automatic test_output_holdoff();
        int n;
        holdoff_req = 300;
        for (n = 0; n < 10; n++)
            send_random_request(10, 60);
        wait_all_results();
    endtask

    // Random traffic with an occasional pause until the block is empty.
    task automatic test_random_traffic(input int count, input int alloc_pct,
                                       input int busy_free_pct);
        int n;
        for (n = 0; n < count; n++) begin
            send_random_request(alloc_pct, busy_free_pct);
            if ($urandom_range(59) == 0)
                wait_all_results();
        end
        wait_all_results();
    endtask

    // Fills the pool, then exercises failed allocations, the hint on a full
    // pool and the bound walking down from the top.
    task automatic test_fill_and_exhaust();
        while (busy_count < POOL_SIZE)
            send_item(OP_ALLOC, SLOT_W'($urandom), OWNER_BITS'($urandom));
        send_item(OP_ALLOC, 10'd0,    8'hFF);
        send_item(OP_ALLOC, 10'd1023, 8'h00);
        send_item(OP_FREE,  10'd1023, 8'h00);
        send_item(OP_ALLOC, 10'd0,    8'h11);
        send_item(OP_FREE,  10'd512,  8'h00);
        send_item(OP_FREE,  10'd700,  8'h00);
        send_item(OP_ALLOC, 10'd0,    8'h22);
        send_item(OP_ALLOC, 10'd0,    8'h33);
        send_item(OP_ALLOC, 10'd0,    8'h44);
        send_item(OP_FREE,  10'd1023, 8'h00);
        send_item(OP_FREE,  10'd1022, 8'h00);
        send_item(OP_FREE,  10'd1021, 8'h00);
        send_item(OP_FREE,  10'd1023, 8'h00);
        wait_all_results();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_corners();
        test_back_to_back();
        test_output_holdoff();
        test_random_traffic(100, 70, 20);
        test_fill_and_exhaust();
        // A crowded pool: allocations often fail and the bound moves near the top.
        test_random_traffic(50, 45, 45);

        // Let any stray result surface before the verdict.
        repeat (NUM_CELLS + 8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
